// ===== rtl/rsc_pkg.sv =====
// rsc_pkg: shared types, register codes and residue group tables
// for the residue similarity scorer; no dependencies
package rsc_pkg;

    // field widths fixed by the item formats
    localparam int RES_W   = 8;
    localparam int WGT_W   = 16;
    localparam int SCORE_W = 28;
    localparam int IDX_W   = 12;
    localparam int CONS_N  = 9;
    localparam int SEMI_N  = 11;

    // largest candidate number that fits the index field
    localparam int INDEX_MAX = 4095;

    // saturation bound of the running score, 2**27 - 1
    localparam logic signed [SCORE_W:0] SCORE_MAX = 29'sd134217727;

    // configuration register indexes
    localparam logic [2:0] REG_W_IDENT = 3'd0;
    localparam logic [2:0] REG_W_CONS  = 3'd1;
    localparam logic [2:0] REG_W_SEMI  = 3'd2;
    localparam logic [2:0] REG_W_MISM  = 3'd3;
    localparam logic [2:0] REG_KEEP    = 3'd4;

    // pair classes, in priority order
    typedef enum logic [1:0] {
        CLS_IDENT,
        CLS_CONS,
        CLS_SEMI,
        CLS_MISM
    } pair_class_t;

    // configuration register set
    typedef struct packed {
        logic signed [WGT_W-1:0] w_ident;
        logic signed [WGT_W-1:0] w_cons;
        logic signed [WGT_W-1:0] w_semi;
        logic signed [WGT_W-1:0] w_mism;
        logic                    keep_max;
    } cfg_t;

    // one residue pair with its run markers
    typedef struct packed {
        logic [RES_W-1:0] first_residue;
        logic [RES_W-1:0] second_residue;
        logic             new_search;
        logic             last_pair;
    } pair_t;

    // conservative groups: NDEQ NEQK STA MILV QHRK NHQK FYW HY MILF (bit 0 first)
    function automatic logic [CONS_N-1:0] cons_bits(input logic [RES_W-1:0] b);
        logic [CONS_N-1:0] bits;
        case (b)
            8'h41:   bits = 9'b000000100; // A
            8'h44:   bits = 9'b000000001; // D
            8'h45:   bits = 9'b000000011; // E
            8'h46:   bits = 9'b101000000; // F
            8'h48:   bits = 9'b010110000; // H
            8'h49:   bits = 9'b100001000; // I
            8'h4B:   bits = 9'b000110010; // K
            8'h4C:   bits = 9'b100001000; // L
            8'h4D:   bits = 9'b100001000; // M
            8'h4E:   bits = 9'b000100011; // N
            8'h51:   bits = 9'b000110011; // Q
            8'h52:   bits = 9'b000010000; // R
            8'h53:   bits = 9'b000000100; // S
            8'h54:   bits = 9'b000000100; // T
            8'h56:   bits = 9'b000001000; // V
            8'h57:   bits = 9'b001000000; // W
            8'h59:   bits = 9'b011000000; // Y
            default: bits = '0;
        endcase
        return bits;
    endfunction

    // semi-conservative groups: SAG ATV CSA SGND STPA STNK NEQHRK NDEQHK
    // SNDEQK HFY FVLIM (bit 0 first)
    function automatic logic [SEMI_N-1:0] semi_bits(input logic [RES_W-1:0] b);
        logic [SEMI_N-1:0] bits;
        case (b)
            8'h41:   bits = 11'b00000010111; // A
            8'h43:   bits = 11'b00000000100; // C
            8'h44:   bits = 11'b00110001000; // D
            8'h45:   bits = 11'b00111000000; // E
            8'h46:   bits = 11'b11000000000; // F
            8'h47:   bits = 11'b00000001001; // G
            8'h48:   bits = 11'b01011000000; // H
            8'h49:   bits = 11'b10000000000; // I
            8'h4B:   bits = 11'b00111100000; // K
            8'h4C:   bits = 11'b10000000000; // L
            8'h4D:   bits = 11'b10000000000; // M
            8'h4E:   bits = 11'b00111101000; // N
            8'h50:   bits = 11'b00000010000; // P
            8'h51:   bits = 11'b00111000000; // Q
            8'h52:   bits = 11'b00001000000; // R
            8'h53:   bits = 11'b00100111101; // S
            8'h54:   bits = 11'b00000110010; // T
            8'h56:   bits = 11'b10000000010; // V
            8'h59:   bits = 11'b01000000000; // Y
            default: bits = '0;
        endcase
        return bits;
    endfunction

endpackage

// ===== rtl/rsc_classify.sv =====
// rsc_classify: classes one residue pair as identical, conservative,
// semi-conservative or mismatch; depends on rsc_pkg
module rsc_classify (
    input  logic [rsc_pkg::RES_W-1:0] first_residue,
    input  logic [rsc_pkg::RES_W-1:0] second_residue,
    output rsc_pkg::pair_class_t      pair_class
);
    import rsc_pkg::*;

    logic cons_hit;
    logic semi_hit;

    // shared group membership of both letters
    assign cons_hit = |(cons_bits(first_residue) & cons_bits(second_residue));
    assign semi_hit = |(semi_bits(first_residue) & semi_bits(second_residue));

    // priority: equal bytes, then conservative, then semi-conservative
    always_comb
    begin
        if (first_residue == second_residue)
            pair_class = CLS_IDENT;
        else if (cons_hit)
            pair_class = CLS_CONS;
        else if (semi_hit)
            pair_class = CLS_SEMI;
        else
            pair_class = CLS_MISM;
    end

endmodule

// ===== rtl/rsc_score.sv =====
// rsc_score: running score, best-candidate tracking and result register
// depends on rsc_pkg and rsc_classify
module rsc_score #(
    parameter int MAX_CANDIDATES = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rsc_pkg::cfg_t         cfg,
    input  rsc_pkg::pair_t        pair,
    input  logic                  step_en,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [71:0]           m_tdata,
    output logic                  m_tuser
);
    import rsc_pkg::*;

    localparam int LIMIT_RAW = MAX_CANDIDATES - 1;
    localparam int CNT_LIMIT = (LIMIT_RAW > INDEX_MAX) ? INDEX_MAX : LIMIT_RAW;
    localparam int CNT_W     = (CNT_LIMIT > 0) ? $clog2(CNT_LIMIT + 1) : 1;
    localparam int PAD_W     = 72 - 2 * SCORE_W - IDX_W;

    pair_class_t                pair_class;
    logic signed [WGT_W:0]      delta;
    logic signed [SCORE_W-1:0]  base;
    logic signed [SCORE_W:0]    sum;
    logic signed [SCORE_W-1:0]  score;
    logic                       best_valid_eff;
    logic [CNT_W-1:0]           count_eff;
    logic                       better;
    logic                       changed;

    logic signed [SCORE_W-1:0]  running_reg, running_next;
    logic signed [SCORE_W-1:0]  kept_reg, kept_next;
    logic [CNT_W-1:0]           kept_idx_reg, kept_idx_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       best_valid_reg, best_valid_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SCORE_W-1:0]  cand_out_reg;
    logic signed [SCORE_W-1:0]  best_out_reg;
    logic [IDX_W-1:0]           idx_out_reg;
    logic                       changed_out_reg;

    rsc_classify u_classify (
        .first_residue  (pair.first_residue),
        .second_residue (pair.second_residue),
        .pair_class     (pair_class)
    );

    // weight selected by class, negated for the subtracting classes
    always_comb
    begin
        case (pair_class)
            CLS_IDENT: delta = {cfg.w_ident[WGT_W-1], cfg.w_ident};
            CLS_CONS:  delta = -{cfg.w_cons[WGT_W-1], cfg.w_cons};
            CLS_SEMI:  delta = -{cfg.w_semi[WGT_W-1], cfg.w_semi};
            default:   delta = -{cfg.w_mism[WGT_W-1], cfg.w_mism};
        endcase
    end

    // a new search drops the partial candidate, the best and the count
    assign base           = pair.new_search ? '0 : running_reg;
    assign best_valid_eff = pair.new_search ? 1'b0 : best_valid_reg;
    assign count_eff      = pair.new_search ? '0 : count_reg;

    // accumulate and saturate
    always_comb
    begin
        sum = {base[SCORE_W-1], base} + {{(SCORE_W - WGT_W){delta[WGT_W]}}, delta};
        if (sum > SCORE_MAX)
            score = SCORE_MAX[SCORE_W-1:0];
        else if (sum < -SCORE_MAX)
            score = SCORE_W'(-SCORE_MAX);
        else
            score = sum[SCORE_W-1:0];
    end

    // strict compare, so ties keep the earlier candidate
    assign better  = cfg.keep_max ? (score > kept_reg) : (score < kept_reg);
    assign changed = !best_valid_eff || better;

    // state update when a pair is consumed
    always_comb
    begin
        running_next    = running_reg;
        kept_next       = kept_reg;
        kept_idx_next   = kept_idx_reg;
        count_next      = count_reg;
        best_valid_next = best_valid_reg;
        if (step_en)
        begin
            running_next    = pair.last_pair ? '0 : score;
            count_next      = count_eff;
            best_valid_next = best_valid_eff;
            if (pair.last_pair)
            begin
                if (changed)
                begin
                    kept_next       = score;
                    kept_idx_next   = count_eff;
                    best_valid_next = 1'b1;
                end
                if (count_eff < CNT_W'(CNT_LIMIT))
                    count_next = count_eff + 1'b1;
            end
        end
    end

    // result register: loads on a last pair, empties on a transfer
    always_comb
    begin
        if (step_en && pair.last_pair)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg    <= '0;
            kept_reg       <= '0;
            kept_idx_reg   <= '0;
            count_reg      <= '0;
            best_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            running_reg    <= running_next;
            kept_reg       <= kept_next;
            kept_idx_reg   <= kept_idx_next;
            count_reg      <= count_next;
            best_valid_reg <= best_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (step_en && pair.last_pair)
        begin
            cand_out_reg    <= score;
            best_out_reg    <= changed ? score : kept_reg;
            idx_out_reg     <= changed ? IDX_W'(count_eff) : IDX_W'(kept_idx_reg);
            changed_out_reg <= changed;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, idx_out_reg, best_out_reg, cand_out_reg};
    assign m_tuser  = changed_out_reg;

endmodule

// ===== rtl/residue_similarity_scorer_top.sv =====
// residue_similarity_scorer_top: input register, configuration registers
// and stream handshake; depends on rsc_pkg and rsc_score
//
// Usage:
//   s_* carries one aligned residue pair per transfer. s_tlast marks the
//   final pair of a candidate, s_tuser flags the first pair of a new search.
//   m_* carries one result per finished candidate: its score, the best
//   score of the search so far, the best candidate number and a flag that
//   says this candidate became the best.
//   Weights and the keep-maximum mode are written through cfg_wen, cfg_index
//   and cfg_wdata; the user does so only while idle, the block does not check.
// Timing:
//   one pair per cycle unless a last pair waits on a busy result slot; the
//   running score is a single saturating add, updated as a pair leaves the
//   input register, where a last pair then loads the result behind m_tvalid.
// Reset:
//   clears both registers stages, the running score, the best and the
//   candidate count; weights go to 0 and keep-maximum to 1.
// Stall:
//   while a result waits, pairs that end no candidate keep flowing; a last
//   pair holds in the input register until the result register frees up.
module residue_similarity_scorer_top #(
    parameter int MAX_CANDIDATES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // pair stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // first_residue[7:0], second_residue[15:8]
    input  logic        s_tuser,   // new_search
    input  logic        s_tlast,   // last_pair
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // candidate_score[27:0], best_score[55:28],
                                   // best_index[67:56], zero pad[71:68]
    output logic        m_tuser    // best_changed
);
    import rsc_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    pair_t pair_reg;
    logic  pair_valid_reg, pair_valid_next;
    logic  out_free;
    logic  step_en;
    logic  in_xfer;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_W_IDENT: cfg_next.w_ident  = cfg_wdata;
                REG_W_CONS:  cfg_next.w_cons   = cfg_wdata;
                REG_W_SEMI:  cfg_next.w_semi   = cfg_wdata;
                REG_W_MISM:  cfg_next.w_mism   = cfg_wdata;
                REG_KEEP:    cfg_next.keep_max = cfg_wdata[0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.w_ident  <= '0;
            cfg_reg.w_cons   <= '0;
            cfg_reg.w_semi   <= '0;
            cfg_reg.w_mism   <= '0;
            cfg_reg.keep_max <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // a pair leaves the input register unless it needs a busy result slot
    assign out_free = !m_tvalid || m_tready;
    assign step_en  = pair_valid_reg && (out_free || !pair_reg.last_pair);
    assign s_tready = !pair_valid_reg || step_en;
    assign in_xfer  = s_tvalid && s_tready;

    always_comb
    begin
        if (in_xfer)
            pair_valid_next = 1'b1;
        else if (step_en)
            pair_valid_next = 1'b0;
        else
            pair_valid_next = pair_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pair_valid_reg <= 1'b0;
        else
            pair_valid_reg <= pair_valid_next;
    end

    // input payload register
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            pair_reg.first_residue  <= s_tdata[7:0];
            pair_reg.second_residue <= s_tdata[15:8];
            pair_reg.new_search     <= s_tuser;
            pair_reg.last_pair      <= s_tlast;
        end
    end

    rsc_score #(
        .MAX_CANDIDATES (MAX_CANDIDATES)
    ) u_score (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .pair     (pair_reg),
        .step_en  (step_en),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== rtl/rsc_checker.sv =====
// rsc_checker: port-level assertions for the residue similarity scorer
// bound to residue_similarity_scorer_top; no package needed
module rsc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        m_tuser
);

    // a stalled result holds its payload
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser));
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("result changed while stalled");

    // a new best reports its own score as the best
    property p_best_matches;
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[55:28] == m_tdata[27:0]);
    endproperty
    a_best_matches: assert property (p_best_matches)
        else $error("best_score differs from candidate_score on a new best");

    // saturation never reaches the most negative code
    property p_score_range;
        @(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[27:0] != 28'h8000000) && (m_tdata[55:28] != 28'h8000000));
    endproperty
    a_score_range: assert property (p_score_range)
        else $error("score outside saturation range");

    // with the result slot empty the input never stalls
    property p_ready_when_empty;
        @(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready;
    endproperty
    a_ready_when_empty: assert property (p_ready_when_empty)
        else $error("input stalled with empty result register");

endmodule

bind residue_similarity_scorer_top rsc_checker u_rsc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
